// ----- design/bmg_pkg.sv -----
// shared types and constants for the bigram byte generator
`timescale 1ns / 1ps
package bmg_pkg;
  localparam int COUNT_WIDTH = 16;
  localparam int ALPHABET = 256;
  localparam int SYM_W = 8;
  localparam int ADDR_W = 16;
  localparam int MEM_DEPTH = 65536;
  localparam int WALK_COLS = (ALPHABET < 256) ? ALPHABET : 255;
  localparam int RND_W = 31;
  localparam int TOT_W = 40;
  localparam logic [RND_W-1:0] MOD_RESET = 31'd100;
  localparam logic [RND_W-1:0] MOD_MAX = 31'h7FFFFFFF;
  localparam logic [TOT_W-1:0] ROUND_LIMIT = 40'd10;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [1:0] {
    OP_LEARN = 2'd0,
    OP_EOL   = 2'd1,
    OP_DRAW  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_BUMP_RD, ST_BUMP_WT, ST_BUMP_WR,
    ST_MOD_START, ST_MOD_RUN, ST_SUM_RD, ST_SUM_ACC, ST_DIV_START, ST_DIV_RUN,
    ST_WALK_RD, ST_WALK_CHK, ST_MODUPD, ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic [TOT_W-1:0] dividend;
    logic [TOT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [TOT_W-1:0] quot;
    logic [TOT_W-1:0] rem;
  } div_rsp_t;
endpackage

// ----- design/bmg_if.sv -----
// valid/ready stream interfaces for input items and results
`timescale 1ns / 1ps
interface bmg_in_if;
  logic valid;
  logic ready;
  logic [1:0] operation;
  logic [7:0] text_byte;
  logic [30:0] random_value;
  modport source (output valid, operation, text_byte, random_value, input ready);
  modport sink (input valid, operation, text_byte, random_value, output ready);
endinterface

interface bmg_out_if;
  logic valid;
  logic ready;
  logic [7:0] next_byte;
  logic line_done;
  modport source (output valid, next_byte, line_done, input ready);
  modport sink (input valid, next_byte, line_done, output ready);
endinterface

// ----- design/bigram_markov_byte_generator_core.sv -----
// bigram byte generator top level: learning, drawing and sequencer
`timescale 1ns / 1ps
// Learns byte-pair counts from training lines (operation 0 bytes, operation 1
// end of line) and draws weighted bytes with operation 2, one result per draw.
// After reset the count memory is cleared, one entry a cycle, all 65536 entries,
// and no item is taken meanwhile. A learn item is a read-modify-write of one
// or two memory entries. A draw runs the modulus reduction, sums the row over
// 255 columns, divides for the whole rounds and walks the columns; the 40-bit
// bit-serial divider and the single memory port set how long a draw lasts.
module bigram_markov_byte_generator_core (
  input logic clk,
  input logic rst_n,
  bmg_in_if.sink in_ch,
  bmg_out_if.source out_ch
);
  import bmg_pkg::*;

  state_t state_r, state_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [SYM_W-1:0] col_r, col_nxt;
  logic [ALPHABET-1:0] present_r;
  logic [SYM_W-1:0] prev_r, cur_r, pick_r;
  logic [1:0] len_r;
  logic [RND_W-1:0] mod_r;
  logic [TOT_W-1:0] k_r, tot_r, rounds_r;
  logic [SYM_W-1:0] b_r;
  logic has_second_r;
  logic we;
  logic [COUNT_WIDTH-1:0] rdata, wdata;
  logic [SYM_W-1:0] out_byte_r;
  logic out_valid_r;
  div_req_t dreq;
  div_rsp_t drsp;
  logic [RND_W:0] mod_grow;
  logic [SYM_W-1:0] row;

  bmg_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(MEM_DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr_r), .wdata(wdata), .rdata(rdata)
  );
  bmg_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign row = cur_r;
  // clearing pass writes zero, otherwise saturating increment
  assign wdata = (state_r == ST_CLEAR) ? '0 :
                 (rdata < COUNT_MAX) ? rdata + 1'b1 : rdata;
  assign mod_grow = {1'b0, mod_r} + {2'b0, mod_r[RND_W-1:1]};
  assign in_ch.ready = (state_r == ST_IDLE) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.next_byte = out_byte_r;
  assign out_ch.line_done = (out_byte_r == '0);

  always_comb begin
    state_nxt = state_r;
    addr_nxt = addr_r;
    col_nxt = col_r;
    we = 1'b0;
    dreq = '0;
    unique case (state_r)
      ST_CLEAR: begin
        we = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == ADDR_W'(MEM_DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: ;
      ST_BUMP_RD: state_nxt = ST_BUMP_WT;
      ST_BUMP_WT: state_nxt = ST_BUMP_WR;
      ST_BUMP_WR: begin
        we = 1'b1;
        state_nxt = has_second_r ? ST_BUMP_RD : ST_IDLE;
      end
      ST_MOD_START: begin
        dreq.start = 1'b1;
        dreq.dividend = k_r;
        dreq.divisor = {{(TOT_W-RND_W){1'b0}}, mod_r};
        state_nxt = ST_MOD_RUN;
      end
      ST_MOD_RUN: if (drsp.done) begin
        if (!present_r[row] || drsp.rem == '0) state_nxt = ST_MODUPD;
        else begin
          state_nxt = ST_SUM_RD;
          col_nxt = '0;
          addr_nxt = {row, {SYM_W{1'b0}}};
        end
      end
      ST_SUM_RD: state_nxt = ST_SUM_ACC;
      ST_SUM_ACC: begin
        if (col_r == SYM_W'(WALK_COLS - 1)) state_nxt = ST_DIV_START;
        else begin
          col_nxt = col_r + 1'b1;
          addr_nxt = {row, col_r + 1'b1};
          state_nxt = ST_SUM_RD;
        end
      end
      ST_DIV_START: begin
        if (tot_r == '0) state_nxt = ST_MODUPD;
        else begin
          dreq.start = 1'b1;
          dreq.dividend = k_r - 1'b1;
          dreq.divisor = tot_r;
          state_nxt = ST_DIV_RUN;
        end
      end
      ST_DIV_RUN: if (drsp.done) begin
        state_nxt = ST_WALK_RD;
        col_nxt = '0;
        addr_nxt = {row, {SYM_W{1'b0}}};
      end
      ST_WALK_RD: state_nxt = ST_WALK_CHK;
      ST_WALK_CHK: begin
        if (rdata != '0 && {{(TOT_W-COUNT_WIDTH){1'b0}}, rdata} >= k_r)
          state_nxt = ST_MODUPD;
        else if (col_r == SYM_W'(WALK_COLS - 1)) state_nxt = ST_MODUPD;
        else begin
          col_nxt = col_r + 1'b1;
          addr_nxt = {row, col_r + 1'b1};
          state_nxt = ST_WALK_RD;
        end
      end
      ST_MODUPD: state_nxt = ST_OUT;
      ST_OUT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    if (state_r == ST_IDLE && in_ch.valid && in_ch.ready) begin
      unique case (op_t'(in_ch.operation))
        OP_LEARN: begin
          if (32'(in_ch.text_byte) < ALPHABET && len_r != 2'd0) begin
            state_nxt = ST_BUMP_RD;
            addr_nxt = (len_r == 2'd1) ? {{SYM_W{1'b0}}, prev_r}
                                       : {prev_r, in_ch.text_byte};
          end
        end
        OP_EOL: if (len_r == 2'd2) begin
          state_nxt = ST_BUMP_RD;
          addr_nxt = {prev_r, {SYM_W{1'b0}}};
        end
        OP_DRAW: state_nxt = ST_MOD_START;
        default: ;
      endcase
    end
    // second pair: old previous byte in b_r, new byte already in prev_r
    if (state_r == ST_BUMP_WR && has_second_r) addr_nxt = {b_r, prev_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      addr_r <= '0;
      col_r <= '0;
      present_r <= '0;
      prev_r <= '0;
      cur_r <= '0;
      len_r <= '0;
      mod_r <= MOD_RESET;
      out_valid_r <= 1'b0;
      has_second_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r <= addr_nxt;
      col_r <= col_nxt;
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      if (state_r == ST_IDLE && in_ch.valid && in_ch.ready) begin
        unique case (op_t'(in_ch.operation))
          OP_LEARN: if (32'(in_ch.text_byte) < ALPHABET) begin
            if (len_r == 2'd1) present_r[0] <= 1'b1;
            if (len_r != 2'd0) present_r[prev_r] <= 1'b1;
            has_second_r <= (len_r == 2'd1);
            b_r <= prev_r;
            if (len_r != 2'd2) len_r <= len_r + 1'b1;
            prev_r <= in_ch.text_byte;
          end
          OP_EOL: begin
            if (len_r == 2'd2) present_r[prev_r] <= 1'b1;
            has_second_r <= 1'b0;
            len_r <= '0;
          end
          OP_DRAW: begin
            if (mod_r == '0) mod_r <= 31'd1;
            k_r <= {{(TOT_W-RND_W){1'b0}}, in_ch.random_value};
            pick_r <= '0;
            tot_r <= '0;
            rounds_r <= '0;
          end
          default: ;
        endcase
      end
      if (state_r == ST_BUMP_WR) has_second_r <= 1'b0;
      if (state_r == ST_MOD_RUN && drsp.done) k_r <= drsp.rem;
      if (state_r == ST_SUM_ACC)
        tot_r <= tot_r + {{(TOT_W-COUNT_WIDTH){1'b0}}, rdata};
      if (state_r == ST_DIV_RUN && drsp.done) begin
        // drop whole rounds, keep 1-based remainder
        k_r <= drsp.rem + 1'b1;
        rounds_r <= drsp.quot + 1'b1;
      end
      if (state_r == ST_WALK_CHK) begin
        if (rdata != '0 && {{(TOT_W-COUNT_WIDTH){1'b0}}, rdata} >= k_r)
          pick_r <= col_r;
        else k_r <= k_r - {{(TOT_W-COUNT_WIDTH){1'b0}}, rdata};
      end
      if (state_r == ST_MODUPD) begin
        if (rounds_r == TOT_W'(1))
          mod_r <= mod_grow[RND_W] ? MOD_MAX : mod_grow[RND_W-1:0];
        else if (rounds_r > ROUND_LIMIT)
          mod_r <= (mod_r[RND_W-1:1] == '0) ? 31'd1 : {1'b0, mod_r[RND_W-1:1]};
      end
      if (state_r == ST_OUT) begin
        out_valid_r <= 1'b1;
        out_byte_r <= pick_r;
        cur_r <= pick_r;
      end
    end
  end
endmodule

// ----- design/bmg_ram.sv -----
// generic single port ram with registered read
`timescale 1ns / 1ps
module bmg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ----- design/bmg_div.sv -----
// radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module bmg_div (
  input  logic clk,
  input  logic rst_n,
  input  bmg_pkg::div_req_t req,
  output bmg_pkg::div_rsp_t rsp
);
  import bmg_pkg::*;
  localparam int CNT_W = $clog2(TOT_W + 1);
  logic [TOT_W-1:0] q_r, rem_r, dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic busy_r, done_r;
  logic [TOT_W:0] trial;

  assign trial = {rem_r, q_r[TOT_W-1]} - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        q_r <= req.dividend;
        rem_r <= '0;
        dvs_r <= req.divisor;
        cnt_r <= CNT_W'(TOT_W);
      end else if (busy_r) begin
        // shift in next dividend bit, keep difference when it fits
        if (!trial[TOT_W]) rem_r <= trial[TOT_W-1:0];
        else rem_r <= {rem_r[TOT_W-2:0], q_r[TOT_W-1]};
        q_r <= {q_r[TOT_W-2:0], ~trial[TOT_W]};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem = rem_r;
endmodule
